// ===== rtl/core/rata_pkg.sv =====
// Shared constants and controller/datapath command types for the running average block.
package rata_pkg;

  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_MAX_AVERAGE = 255;
  localparam int COUNT_BITS = 8;
  localparam int TARE_AFTER_BITS = 16;
  localparam int TARE_BITS = 17;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [COUNT_BITS-1:0] RESTART_AVERAGE_COUNT = 8'd8;
  localparam logic [COUNT_BITS-1:0] RESET_AVERAGE_COUNT = 8'd8;
  localparam logic [TARE_AFTER_BITS-1:0] RESET_TARE_AFTER = 16'd30;
  localparam logic [TARE_BITS-1:0] TARE_COUNTER_MAX = 17'h1FFFF;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_AVERAGE_COUNT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARE_AFTER = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_load;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_restart;
  } dp_status_t;

endpackage

// ===== rtl/core/rata_in_if.sv =====
// Input channel carrying a sample or restart transaction.
interface rata_in_if import rata_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source(output valid, output kind, output sample, input ready);
  modport sink(input valid, input kind, input sample, output ready);
endinterface

// ===== rtl/core/rata_out_if.sv =====
// Output channel carrying the average, tare offset and tare status.
interface rata_out_if import rata_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic signed [SAMPLE_BITS-1:0] tare_offset;
  logic                          tare_done;

  modport source(output valid, output average, output tare_offset, output tare_done,
                 input ready);
  modport sink(input valid, input average, input tare_offset, input tare_done,
               output ready);
endinterface

// ===== rtl/core/rata_ctrl.sv =====
// Sequencer for accept, total update, iterative divide and result hand-off.
module rata_ctrl import rata_pkg::*; #(
  parameter int TOTAL_BITS = DEF_SAMPLE_BITS + COUNT_BITS + 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int CNT_W = $clog2(TOTAL_BITS);

  typedef enum logic [2:0] {IDLE, UPD, PREP, DIV, FIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             out_free;
  logic             div_last;

  assign out_free = !out_valid || out_ready;
  assign div_last = (cnt == CNT_W'(TOTAL_BITS - 1));
  assign in_ready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == IDLE) && in_valid;
    cmd.update   = (state == UPD) && !status.is_restart;
    cmd.div_load = (state == PREP);
    cmd.div_step = (state == DIV);
    cmd.finish   = (state == FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready && !cmd.finish) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= UPD;
          end
        end
        UPD: begin
          if (status.is_restart) begin
            state <= FIN;
          end else begin
            state <= PREP;
          end
        end
        PREP: begin
          cnt   <= '0;
          state <= DIV;
        end
        DIV: begin
          cnt <= cnt + 1'b1;
          if (div_last) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rata_dp.sv =====
// Datapath: configuration, running total, restoring divider and tare logic.
module rata_dp import rata_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int MAX_AVERAGE = DEF_MAX_AVERAGE,
  parameter int TOTAL_BITS  = DEF_SAMPLE_BITS + COUNT_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_kind,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  output logic signed [SAMPLE_BITS-1:0] average,
  output logic signed [SAMPLE_BITS-1:0] tare_offset,
  output logic                          tare_done
);

  localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_AVERAGE);
  localparam logic signed [TOTAL_BITS:0] AVG_HI =
    (TOTAL_BITS+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [TOTAL_BITS:0] AVG_LO = -AVG_HI - 1;

  logic [COUNT_BITS-1:0]         average_count;
  logic [TARE_AFTER_BITS-1:0]    tare_after;
  logic signed [TOTAL_BITS-1:0]  sample_total;
  logic [COUNT_BITS-1:0]         samples_held;
  logic [TARE_BITS-1:0]          tare_counter;
  logic                          kind_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [TOTAL_BITS-1:0]         div_quot;
  logic [COUNT_BITS-1:0]         div_rem;
  logic                          div_neg;

  logic [COUNT_BITS-1:0]         eff_count;
  logic [COUNT_BITS:0]           rem_shift;
  logic                          rem_ge;
  logic signed [TOTAL_BITS:0]    quot_signed;
  logic signed [SAMPLE_BITS-1:0] avg_next;
  logic [TARE_BITS-1:0]          tare_inc;

  assign status.is_restart = (kind_q == KIND_RESTART);

  always_comb begin
    eff_count = average_count;
    if (eff_count == '0) begin
      eff_count = COUNT_BITS'(1);
    end
    if (eff_count > MAX_COUNT) begin
      eff_count = MAX_COUNT;
    end
  end

  assign rem_shift = {div_rem, div_quot[TOTAL_BITS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, samples_held});

  always_comb begin
    quot_signed = $signed({1'b0, div_quot});
    if (div_neg) begin
      quot_signed = -quot_signed;
    end
    if (quot_signed > AVG_HI) begin
      avg_next = SAMPLE_BITS'(AVG_HI);
    end else if (quot_signed < AVG_LO) begin
      avg_next = SAMPLE_BITS'(AVG_LO);
    end else begin
      avg_next = SAMPLE_BITS'(quot_signed);
    end
  end

  assign tare_inc = (tare_counter < TARE_COUNTER_MAX) ? tare_counter + 1'b1 : tare_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_count <= RESET_AVERAGE_COUNT;
      tare_after    <= RESET_TARE_AFTER;
      sample_total  <= '0;
      samples_held  <= '0;
      average       <= '0;
      tare_counter  <= '0;
      tare_done     <= 1'b0;
      tare_offset   <= '0;
      kind_q        <= KIND_SAMPLE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AVERAGE_COUNT: average_count <= cfg_data[COUNT_BITS-1:0];
          CFG_TARE_AFTER:    tare_after    <= cfg_data[TARE_AFTER_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.capture) begin
        kind_q <= in_kind;
      end
      if (cmd.update) begin
        if (samples_held < eff_count) begin
          sample_total <= sample_total + TOTAL_BITS'(sample_q);
          samples_held <= samples_held + 1'b1;
        end else begin
          sample_total <= sample_total - TOTAL_BITS'(average) + TOTAL_BITS'(sample_q);
        end
      end
      if (cmd.finish) begin
        if (kind_q == KIND_RESTART) begin
          tare_offset   <= '0;
          average       <= '0;
          tare_counter  <= '0;
          tare_done     <= 1'b0;
          average_count <= RESTART_AVERAGE_COUNT;
        end else begin
          average <= avg_next;
          if (tare_counter > TARE_BITS'(tare_after) && !tare_done) begin
            tare_counter <= '0;
            tare_done    <= 1'b1;
            tare_offset  <= avg_next;
          end else begin
            tare_counter <= tare_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= in_sample;
    end
    if (cmd.div_load) begin
      div_neg  <= sample_total[TOTAL_BITS-1];
      div_rem  <= '0;
      div_quot <= sample_total[TOTAL_BITS-1] ? TOTAL_BITS'(-sample_total)
                                             : TOTAL_BITS'(sample_total);
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        div_rem <= COUNT_BITS'(rem_shift - {1'b0, samples_held});
      end else begin
        div_rem <= rem_shift[COUNT_BITS-1:0];
      end
      div_quot <= {div_quot[TOTAL_BITS-2:0], rem_ge};
    end
  end

endmodule

// ===== rtl/core/running_average_with_auto_tare_top.sv =====
// Top level of the running average block with automatic tare.
//
//   Channel   Direction  Transaction contents
//   in_ch     sink       kind, sample
//   out_ch    source     average, tare_offset, tare_done
//   cfg_*     write      average_count (index 0), tare_after (index 1)
//
// A sample result passes the UPD, PREP, DIV and FIN states after acceptance; DIV runs
// the one-bit-per-cycle restoring divider over the SAMPLE_BITS + 9 bit total, and a new
// sample is accepted only back in IDLE. A restart result skips PREP and DIV. Reset is
// synchronous and returns the state and all registers but the sample and divider ones
// to their reset values. The next transaction is accepted while a result waits on
// out_ch; a stalled output only holds the block once a new result is ready.
module running_average_with_auto_tare_top import rata_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int MAX_AVERAGE = DEF_MAX_AVERAGE
) (
  input  logic                      clk,
  input  logic                      rst,
  rata_in_if.sink                   in_ch,
  rata_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int TOTAL_BITS = SAMPLE_BITS + COUNT_BITS + 1;

  dp_cmd_t    cmd;
  dp_status_t status;

  rata_ctrl #(
    .TOTAL_BITS(TOTAL_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rata_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_AVERAGE(MAX_AVERAGE),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (in_ch.kind),
    .in_sample  (in_ch.sample),
    .cmd        (cmd),
    .status     (status),
    .average    (out_ch.average),
    .tare_offset(out_ch.tare_offset),
    .tare_done  (out_ch.tare_done)
  );

endmodule
